[rtl/ced_pkg.sv]
// ced_pkg: shared types and widths for the circle elastic collision pipeline.
// No dependencies.
`default_nettype none

package ced_pkg;

   // Widths of the internal datapath once a touching pair is known.
   localparam int NUM_W     = 56;  // rounded quotient numerator magnitude
   localparam int DEN_W     = 38;  // (m1+m2)*|d|^2
   localparam int QUO_W     = 20;  // quotient magnitude, < 2^18 in practice
   localparam int DIV_STEPS = 2;   // quotient bits per divider stage

   typedef struct packed {
      logic signed [15:0] first_pos_x;
      logic signed [15:0] first_pos_y;
      logic signed [15:0] first_vel_x;
      logic signed [15:0] first_vel_y;
      logic        [7:0]  first_radius;
      logic        [9:0]  first_mass;
      logic signed [15:0] second_pos_x;
      logic signed [15:0] second_pos_y;
      logic signed [15:0] second_vel_x;
      logic signed [15:0] second_vel_y;
      logic        [7:0]  second_radius;
      logic        [9:0]  second_mass;
   } ced_req_type;

   typedef struct packed {
      logic signed [15:0] new_first_vel_x;
      logic signed [15:0] new_first_vel_y;
      logic signed [15:0] new_second_vel_x;
      logic signed [15:0] new_second_vel_y;
      logic               bounced;
      logic               clipped;
   } ced_rsp_type;

   // Per-item data carried alongside the dividers.
   typedef struct packed {
      logic signed [15:0] v1x;
      logic signed [15:0] v1y;
      logic signed [15:0] v2x;
      logic signed [15:0] v2y;
      logic               hit;
      logic [3:0]         neg;  // sign of each quotient: n1x, n1y, n2x, n2y
   } ced_side_type;

endpackage

`default_nettype wire

[rtl/circle_elastic_collision_top.sv]
// circle_elastic_collision_top: 2D elastic collision of two circles, pipelined.
// Depends on ced_pkg and ced_div.
//
//   channel | ports                          | direction | moves
//   req     | req_valid req_stall req_data   | in        | one circle pair per transfer
//   rsp     | rsp_valid rsp_stall rsp_data   | out       | new velocities and flags
//
// One pair enters per cycle while req_stall is low. Each pair passes six
// arithmetic stages, the divider pipeline (10 stages by default) and the
// output register. Sync reset clears only the valid bits. A stall on rsp
// freezes the whole pipeline while the output register holds a result;
// req_stall then follows, so nothing is dropped or repeated.
`default_nettype none

module circle_elastic_collision_top #(
   parameter int DIV_STEPS = ced_pkg::DIV_STEPS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ced_pkg::ced_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ced_pkg::ced_rsp_type      rsp_data
);
   import ced_pkg::*;

   localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   logic en;
   logic rsp_valid_ff;
   ced_rsp_type rsp_data_ff, rsp_data_in;

   // pipeline advances unless a finished result is held
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // ---- stage A: differences, sums
   logic               val_a_ff;
   logic signed [16:0] dx_a_ff, dy_a_ff, dvx_a_ff, dvy_a_ff;
   logic [8:0]         rs_a_ff;
   logic [10:0]        ms_a_ff;
   logic [9:0]         m1_a_ff, m2_a_ff;
   logic signed [15:0] v1x_a_ff, v1y_a_ff, v2x_a_ff, v2y_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_a_ff <= 1'b0;
      end else if (en) begin
         val_a_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_a_ff  <= {req_data.first_pos_x[15], req_data.first_pos_x}
                   - {req_data.second_pos_x[15], req_data.second_pos_x};
         dy_a_ff  <= {req_data.first_pos_y[15], req_data.first_pos_y}
                   - {req_data.second_pos_y[15], req_data.second_pos_y};
         dvx_a_ff <= {req_data.first_vel_x[15], req_data.first_vel_x}
                   - {req_data.second_vel_x[15], req_data.second_vel_x};
         dvy_a_ff <= {req_data.first_vel_y[15], req_data.first_vel_y}
                   - {req_data.second_vel_y[15], req_data.second_vel_y};
         rs_a_ff  <= {1'b0, req_data.first_radius} + {1'b0, req_data.second_radius};
         ms_a_ff  <= {1'b0, req_data.first_mass} + {1'b0, req_data.second_mass};
         m1_a_ff  <= req_data.first_mass;
         m2_a_ff  <= req_data.second_mass;
         v1x_a_ff <= req_data.first_vel_x;
         v1y_a_ff <= req_data.first_vel_y;
         v2x_a_ff <= req_data.second_vel_x;
         v2y_a_ff <= req_data.second_vel_y;
      end
   end

   // ---- stage B: squares and dot-product terms
   logic               val_b_ff;
   logic signed [33:0] sqx_b_ff, sqy_b_ff, dtx_b_ff, dty_b_ff;
   logic [25:0]        rs2_b_ff;
   logic signed [16:0] dx_b_ff, dy_b_ff;
   logic [10:0]        ms_b_ff;
   logic [9:0]         m1_b_ff, m2_b_ff;
   logic signed [15:0] v1x_b_ff, v1y_b_ff, v2x_b_ff, v2y_b_ff;
   logic [12:0]        rs16_a;

   assign rs16_a = {rs_a_ff, 4'b0000};

   always_ff @(posedge clock) begin
      if (reset) begin
         val_b_ff <= 1'b0;
      end else if (en) begin
         val_b_ff <= val_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_b_ff <= dx_a_ff * dx_a_ff;
         sqy_b_ff <= dy_a_ff * dy_a_ff;
         dtx_b_ff <= dvx_a_ff * dx_a_ff;
         dty_b_ff <= dvy_a_ff * dy_a_ff;
         rs2_b_ff <= 26'(rs16_a) * 26'(rs16_a);
         dx_b_ff  <= dx_a_ff;
         dy_b_ff  <= dy_a_ff;
         ms_b_ff  <= ms_a_ff;
         m1_b_ff  <= m1_a_ff;
         m2_b_ff  <= m2_a_ff;
         v1x_b_ff <= v1x_a_ff;
         v1y_b_ff <= v1y_a_ff;
         v2x_b_ff <= v2x_a_ff;
         v2y_b_ff <= v2y_a_ff;
      end
   end

   // ---- stage C: |d|^2, dot, collision test
   // Once touching, |d|^2 < 2^26, |dx| < 2^14 and |dot| < 2^30, so the
   // narrowed copies below are exact whenever hit is set.
   logic               val_c_ff, hit_c_ff;
   logic [34:0]        d2_c;
   logic signed [34:0] dot_c;
   logic [25:0]        d2_c_ff;
   logic signed [30:0] dot_c_ff;
   logic signed [14:0] dx_c_ff, dy_c_ff;
   logic [10:0]        ms_c_ff;
   logic [9:0]         m1_c_ff, m2_c_ff;
   logic signed [15:0] v1x_c_ff, v1y_c_ff, v2x_c_ff, v2y_c_ff;
   logic               hit_c;

   assign d2_c  = {1'b0, sqx_b_ff} + {1'b0, sqy_b_ff};
   assign dot_c = {dtx_b_ff[33], dtx_b_ff} + {dty_b_ff[33], dty_b_ff};
   // approaching means dv.(p2-p1) >= 0, i.e. dot <= 0
   assign hit_c = (d2_c <= 35'(rs2_b_ff)) && (d2_c != '0) && (ms_b_ff != '0)
                  && (dot_c[34] || (dot_c == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         val_c_ff <= 1'b0;
      end else if (en) begin
         val_c_ff <= val_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_c_ff <= hit_c;
         d2_c_ff  <= d2_c[25:0];
         dot_c_ff <= dot_c[30:0];
         dx_c_ff  <= dx_b_ff[14:0];
         dy_c_ff  <= dy_b_ff[14:0];
         ms_c_ff  <= ms_b_ff;
         m1_c_ff  <= m1_b_ff;
         m2_c_ff  <= m2_b_ff;
         v1x_c_ff <= v1x_b_ff;
         v1y_c_ff <= v1y_b_ff;
         v2x_c_ff <= v2x_b_ff;
         v2y_c_ff <= v2y_b_ff;
      end
   end

   // ---- stage D: denominator and mass-weighted dot
   logic               val_d_ff, hit_d_ff;
   logic [DEN_W-1:0]   den_d_ff;
   logic signed [40:0] mp1_d, mp2_d;
   logic signed [41:0] k1_d_ff, k2_d_ff;
   logic signed [14:0] dx_d_ff, dy_d_ff;
   logic signed [15:0] v1x_d_ff, v1y_d_ff, v2x_d_ff, v2y_d_ff;

   assign mp1_d = $signed({1'b0, m2_c_ff}) * dot_c_ff;
   assign mp2_d = $signed({1'b0, m1_c_ff}) * dot_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_d_ff <= 1'b0;
      end else if (en) begin
         val_d_ff <= val_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_d_ff <= hit_c_ff;
         den_d_ff <= DEN_W'(ms_c_ff) * DEN_W'(d2_c_ff);
         k1_d_ff  <= {mp1_d, 1'b0};
         k2_d_ff  <= {mp2_d, 1'b0};
         dx_d_ff  <= dx_c_ff;
         dy_d_ff  <= dy_c_ff;
         v1x_d_ff <= v1x_c_ff;
         v1y_d_ff <= v1y_c_ff;
         v2x_d_ff <= v2x_c_ff;
         v2y_d_ff <= v2y_c_ff;
      end
   end

   // ---- stage E: signed numerators k*d
   logic               val_e_ff, hit_e_ff;
   logic [DEN_W-1:0]   den_e_ff;
   logic signed [55:0] n1x_e_ff, n1y_e_ff, n2x_e_ff, n2y_e_ff;
   logic signed [15:0] v1x_e_ff, v1y_e_ff, v2x_e_ff, v2y_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_e_ff <= 1'b0;
      end else if (en) begin
         val_e_ff <= val_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_e_ff <= hit_d_ff;
         den_e_ff <= den_d_ff;
         n1x_e_ff <= k1_d_ff * dx_d_ff;
         n1y_e_ff <= k1_d_ff * dy_d_ff;
         n2x_e_ff <= k2_d_ff * dx_d_ff;
         n2y_e_ff <= k2_d_ff * dy_d_ff;
         v1x_e_ff <= v1x_d_ff;
         v1y_e_ff <= v1y_d_ff;
         v2x_e_ff <= v2x_d_ff;
         v2y_e_ff <= v2y_d_ff;
      end
   end

   // ---- stage F: magnitude plus half divisor (round half away from zero)
   logic               val_f_ff;
   ced_side_type       side_f_ff;
   logic [DEN_W-1:0]   den_f_ff;
   logic [NUM_W-1:0]   num_f_ff [4];
   logic signed [55:0] nsel [4];
   logic [55:0]        nmag [4];

   assign nsel[0] = n1x_e_ff;
   assign nsel[1] = n1y_e_ff;
   assign nsel[2] = n2x_e_ff;
   assign nsel[3] = n2y_e_ff;

   for (genvar i = 0; i < 4; i++) begin : g_mag
      assign nmag[i] = nsel[i][55] ? 56'(-nsel[i]) : 56'(nsel[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_f_ff <= 1'b0;
      end else if (en) begin
         val_f_ff <= val_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_f_ff      <= den_e_ff;
         side_f_ff.v1x <= v1x_e_ff;
         side_f_ff.v1y <= v1y_e_ff;
         side_f_ff.v2x <= v2x_e_ff;
         side_f_ff.v2y <= v2y_e_ff;
         side_f_ff.hit <= hit_e_ff;
         for (int i = 0; i < 4; i++) begin
            side_f_ff.neg[i] <= nsel[i][55];
            num_f_ff[i]      <= NUM_W'(nmag[i]) + NUM_W'(den_e_ff >> 1);
         end
      end
   end

   // ---- divider stages
   logic [QUO_W-1:0] quo [4];

   for (genvar i = 0; i < 4; i++) begin : g_div
      ced_div #(
         .STEPS (DIV_STEPS)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_f_ff[i]),
         .den   (den_f_ff),
         .quo   (quo[i])
      );
   end

   logic         val_s_ff  [DIV_STAGES];
   ced_side_type side_s_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            val_s_ff[s] <= 1'b0;
         end else if (en) begin
            val_s_ff[s] <= (s == 0) ? val_f_ff : val_s_ff[(s == 0) ? 0 : s - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_s_ff[s] <= (s == 0) ? side_f_ff : side_s_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // ---- output stage: apply change, saturate
   ced_side_type       side_o;
   logic signed [21:0] vold [4];
   logic signed [21:0] vsum [4];
   logic signed [15:0] vsat [4];
   logic [3:0]         sat_hit;

   assign side_o  = side_s_ff[DIV_STAGES-1];
   assign vold[0] = 22'(side_o.v1x);
   assign vold[1] = 22'(side_o.v1y);
   assign vold[2] = 22'(side_o.v2x);
   assign vold[3] = 22'(side_o.v2y);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         // first circle subtracts the rounded change, second adds it
         if (side_o.neg[i] == (i < 2)) begin
            vsum[i] = vold[i] + $signed({2'b00, quo[i]});
         end else begin
            vsum[i] = vold[i] - $signed({2'b00, quo[i]});
         end
         if (vsum[i] > 22'sd32767) begin
            vsat[i]    = 16'sh7fff;
            sat_hit[i] = 1'b1;
         end else if (vsum[i] < -22'sd32768) begin
            vsat[i]    = -16'sh8000;
            sat_hit[i] = 1'b1;
         end else begin
            vsat[i]    = vsum[i][15:0];
            sat_hit[i] = 1'b0;
         end
      end
      if (side_o.hit) begin
         rsp_data_in.new_first_vel_x  = vsat[0];
         rsp_data_in.new_first_vel_y  = vsat[1];
         rsp_data_in.new_second_vel_x = vsat[2];
         rsp_data_in.new_second_vel_y = vsat[3];
         rsp_data_in.bounced          = 1'b1;
         rsp_data_in.clipped          = |sat_hit;
      end else begin
         rsp_data_in.new_first_vel_x  = side_o.v1x;
         rsp_data_in.new_first_vel_y  = side_o.v1y;
         rsp_data_in.new_second_vel_x = side_o.v2x;
         rsp_data_in.new_second_vel_y = side_o.v2y;
         rsp_data_in.bounced          = 1'b0;
         rsp_data_in.clipped          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= val_s_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks
   // saturation is only possible on a bounce
   a_clip_needs_bounce: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.clipped || rsp_data.bounced))
      else $error("clipped without bounced");

   // input is only held back by a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // narrowing of |d|^2 after stage C is exact for touching pairs
   a_narrow_d2: assert property (@(posedge clock) disable iff (reset)
      (val_b_ff && hit_c) |-> (d2_c[34:26] == '0))
      else $error("distance squared exceeds narrowed width");

endmodule

`default_nettype wire

[rtl/ced_div.sv]
// ced_div: pipelined restoring divider, STEPS quotient bits per stage.
// Depends on ced_pkg.
`default_nettype none

module ced_div #(
   parameter int STEPS = ced_pkg::DIV_STEPS
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [ced_pkg::NUM_W-1:0]  num,
   input  wire logic [ced_pkg::DEN_W-1:0]  den,
   output logic      [ced_pkg::QUO_W-1:0]  quo
);
   import ced_pkg::*;

   localparam int STAGES = (QUO_W + STEPS - 1) / STEPS;
   localparam int RW     = DEN_W + QUO_W;

   logic [RW-1:0]    rem_ff [STAGES];
   logic [RW-1:0]    rem_in [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [QUO_W-1:0] quo_ff [STAGES];
   logic [QUO_W-1:0] quo_in [STAGES];
   logic [RW-1:0]    src_rem [STAGES];
   logic [DEN_W-1:0] src_den [STAGES];
   logic [QUO_W-1:0] src_quo [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s] = RW'(num);
         assign src_den[s] = den;
         assign src_quo[s] = '0;
      end else begin : g_next
         assign src_rem[s] = rem_ff[s-1];
         assign src_den[s] = den_ff[s-1];
         assign src_quo[s] = quo_ff[s-1];
      end

      always_comb begin
         logic [RW-1:0]    r;
         logic [QUO_W-1:0] q;
         logic [RW-1:0]    trial;
         r = src_rem[s];
         q = src_quo[s];
         trial = '0;
         for (int j = 0; j < STEPS; j++) begin
            if (QUO_W - 1 - s * STEPS - j >= 0) begin
               trial = RW'(src_den[s]) << (QUO_W - 1 - s * STEPS - j);
               if (r >= trial) begin
                  r = r - trial;
                  q[QUO_W - 1 - s * STEPS - j] = 1'b1;
               end
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= src_den[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

`default_nettype wire

[verif/circle_elastic_collision_top_tb.sv]
// Testbench for circle_elastic_collision_top: drives circle pairs and checks velocities.
// The expected results come from an in-bench integer collision calculator.
// Depends on ced_pkg and the RTL of the top level.
`default_nettype none

module circle_elastic_collision_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ced_pkg::*;

   localparam int LATENCY     = 7 + (QUO_W / DIV_STEPS);
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ced_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ced_rsp_type rsp_data;

   circle_elastic_collision_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ced_rsp_type pending_vel_q[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;   // sender idle chance, percent
   int          recv_idle_pct = 0;   // receiver stall chance, percent
   int          hold_cycles = 0;     // long receiver hold-off, counted below

   // Signed rounding division, ties away from zero; den is positive.
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic [15:0] clamp16(longint v, ref logic clip);
      if (v > 32767) begin
         clip = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         clip = 1'b1;
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Collision response for one pair.
   function automatic ced_rsp_type collide(ced_req_type p);
      ced_rsp_type r;
      longint dx, dy, dist2, rsum, msum, dot, den, k1, k2;
      logic clip;
      clip = 1'b0;
      r.new_first_vel_x  = p.first_vel_x;
      r.new_first_vel_y  = p.first_vel_y;
      r.new_second_vel_x = p.second_vel_x;
      r.new_second_vel_y = p.second_vel_y;
      r.bounced = 1'b0;
      dx = longint'(p.first_pos_x) - longint'(p.second_pos_x);
      dy = longint'(p.first_pos_y) - longint'(p.second_pos_y);
      dist2 = dx * dx + dy * dy;
      rsum = (longint'(p.first_radius) + longint'(p.second_radius)) * 16;
      msum = longint'(p.first_mass) + longint'(p.second_mass);
      dot = (longint'(p.first_vel_x) - longint'(p.second_vel_x)) * dx
          + (longint'(p.first_vel_y) - longint'(p.second_vel_y)) * dy;
      if (dist2 <= rsum * rsum && dist2 != 0 && msum != 0 && dot <= 0) begin
         den = msum * dist2;
         k1 = 2 * longint'(p.second_mass) * dot;
         k2 = 2 * longint'(p.first_mass) * dot;
         r.bounced = 1'b1;
         r.new_first_vel_x  = clamp16(longint'(p.first_vel_x) - round_div(k1 * dx, den), clip);
         r.new_first_vel_y  = clamp16(longint'(p.first_vel_y) - round_div(k1 * dy, den), clip);
         r.new_second_vel_x = clamp16(longint'(p.second_vel_x) + round_div(k2 * dx, den), clip);
         r.new_second_vel_y = clamp16(longint'(p.second_vel_y) + round_div(k2 * dy, den), clip);
      end
      r.clipped = clip;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      mismatch_count++;
   endtask

   // Offer one pair; hold it until the transfer happens.
   // Valid stays high on return so back-to-back pairs need no gap.
   task automatic send_pair(ced_req_type p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      pending_vel_q = {pending_vel_q, collide(p)};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver: random stall, plus long hold-off when requested.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Checker: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      ced_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vel_q.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = pending_vel_q.pop_front();
            if (rsp_data.new_first_vel_x !== want.new_first_vel_x)
               report_mismatch("new_first_vel_x", rsp_data.new_first_vel_x, want.new_first_vel_x);
            if (rsp_data.new_first_vel_y !== want.new_first_vel_y)
               report_mismatch("new_first_vel_y", rsp_data.new_first_vel_y, want.new_first_vel_y);
            if (rsp_data.new_second_vel_x !== want.new_second_vel_x)
               report_mismatch("new_second_vel_x", rsp_data.new_second_vel_x,
                               want.new_second_vel_x);
            if (rsp_data.new_second_vel_y !== want.new_second_vel_y)
               report_mismatch("new_second_vel_y", rsp_data.new_second_vel_y,
                               want.new_second_vel_y);
            if (rsp_data.bounced !== want.bounced)
               report_mismatch("bounced", rsp_data.bounced, want.bounced);
            if (rsp_data.clipped !== want.clipped)
               report_mismatch("clipped", rsp_data.clipped, want.clipped);
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic ced_req_type rand_pair();
      ced_req_type  p;
      logic [191:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = bits[$bits(ced_req_type)-1:0];
      return p;
   endfunction

   // Pair that often touches: mostly a small offset, random content.
   function automatic ced_req_type touching_pair();
      ced_req_type p;
      int span;
      p = rand_pair();
      span = $urandom_range(3) == 0 ? 16000 : 300;
      p.first_radius  = 8'($urandom_range(255));
      p.second_radius = 8'($urandom_range(255));
      p.second_pos_x = p.first_pos_x + $signed(16'($urandom_range(2 * span) - span));
      p.second_pos_y = p.first_pos_y + $signed(16'($urandom_range(2 * span) - span));
      if ($urandom_range(3) != 0) begin
         p.first_vel_x  = $signed(16'($urandom_range(4000))) - 16'sd2000;
         p.first_vel_y  = $signed(16'($urandom_range(4000))) - 16'sd2000;
         p.second_vel_x = $signed(16'($urandom_range(4000))) - 16'sd2000;
         p.second_vel_y = $signed(16'($urandom_range(4000))) - 16'sd2000;
      end
      return p;
   endfunction

   task automatic test_directed();
      ced_req_type p;
      // Not touching.
      p = '0; p.first_pos_x = 16'sh7fff; p.second_pos_x = 16'sh8000;
      p.first_mass = 10'd1; p.second_mass = 10'd1; p.first_vel_x = 16'sh8000;
      send_pair(p);
      // Zero distance.
      p = '0; p.first_radius = 8'd10; p.first_mass = 10'd5; p.second_mass = 10'd5;
      p.first_vel_x = 16'sd100; send_pair(p);
      // Both masses zero.
      p = '0; p.first_pos_x = 16'sd16; p.first_radius = 8'd4;
      p.first_vel_x = -16'sd256; send_pair(p);
      // One mass zero, head-on.
      p = '0; p.first_pos_x = 16'sd32; p.first_radius = 8'd2; p.second_mass = 10'd7;
      p.first_vel_x = -16'sd512; send_pair(p);
      // Zero relative approach.
      p = '0; p.first_pos_x = 16'sd32; p.first_radius = 8'd2; p.first_mass = 10'd3;
      p.second_mass = 10'd3; p.first_vel_y = 16'sd300; send_pair(p);
      // Moving apart.
      p = '0; p.first_pos_x = 16'sd32; p.first_radius = 8'd2; p.first_mass = 10'd3;
      p.second_mass = 10'd3; p.first_vel_x = 16'sd300; send_pair(p);
      // Tiny change to the first circle that rounds to zero.
      p = '0; p.first_pos_x = 16'sd4000; p.first_radius = 8'd255; p.first_mass = 10'd1023;
      p.second_mass = 10'd1; p.first_vel_x = -16'sd1; send_pair(p);
      // Saturation, extreme masses and velocities.
      p = '0; p.first_pos_x = 16'sd1; p.first_pos_y = 16'sd1; p.first_radius = 8'd255;
      p.second_radius = 8'd255; p.first_mass = 10'd1; p.second_mass = 10'd1023;
      p.first_vel_x = 16'sh8000; p.first_vel_y = 16'sh8000;
      p.second_vel_x = 16'sh7fff; p.second_vel_y = 16'sh7fff; send_pair(p);
      p.first_mass = 10'd1023; p.second_mass = 10'd1; send_pair(p);
      // Extreme positions at opposite ends of the range, not touching.
      p = '0; p.first_pos_x = 16'sh8000; p.first_pos_y = 16'sh8000;
      p.second_pos_x = 16'sh7fff; p.second_pos_y = 16'sh7fff;
      p.first_radius = 8'd255; p.second_radius = 8'd255; p.first_mass = 10'd1023;
      p.second_mass = 10'd1023; p.first_vel_x = 16'sh7fff; p.first_vel_y = 16'sh7fff;
      send_pair(p);
      p = '1; send_pair(p);
      for (int i = 0; i < 10; i++) send_pair(touching_pair());
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 7) send_pair(touching_pair());
         else send_pair(rand_pair());
      end
   endtask

   // Long receiver hold-off while the sender keeps offering.
   task automatic test_backpressure();
      req_valid <= 1'b0;
      @(posedge clock);
      hold_cycles <= 60;
      test_random(60);
   endtask

   initial begin
      int drain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 12; recv_idle_pct = 57;
      test_random(330);
      send_idle_pct = 57; recv_idle_pct = 12;
      test_random(330);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(310);
      req_valid <= 1'b0;
      // Drain: wait for every result, then a little extra latency.
      drain = 0;
      while (pending_vel_q.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_vel_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
